[sv/dcfx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcfx_pkg
// Shared types and constants for the DER context field extractor: tag codes,
// status codes, register indexes and the structs that travel between modules.
// ----------------------------------------------------------------------------
package dcfx_pkg;

	// Longest long-form length that is accepted, in octets.
	localparam int unsigned MAX_LENGTH_OCTETS = 4;
	localparam int unsigned LEN_CNT_W         = $clog2(MAX_LENGTH_OCTETS + 1);

	// Tag codes.
	localparam logic [7:0] TAG_CTX_CONSTRUCTED = 8'hA0;
	localparam logic [7:0] TAG_CTX_PRIMITIVE   = 8'h80;
	localparam logic [7:0] TAG_INTEGER         = 8'h02;
	localparam logic [7:0] TAG_OCTET_STRING    = 8'h04;
	localparam logic [7:0] TAG_GENERAL_STRING  = 8'h1B;
	localparam logic [7:0] TAG_BMP_STRING      = 8'h1E;

	// Length octet fields.
	localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;

	// Status codes reported on the last byte.
	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_TAG_MISS  = 3'd3;
	localparam logic [2:0] ST_BAD_INT   = 3'd4;

	// Register indexes on the configuration port (word address).
	localparam logic [1:0] REG_CONTEXT_NUMBER   = 2'd0;
	localparam logic [1:0] REG_INNER_TAG_WANTED = 2'd1;
	localparam logic [1:0] REG_DECODE_INTEGER   = 2'd2;

	localparam int unsigned PADDR_W = 4;

	typedef struct packed {
		logic [4:0] context_number;
		logic [7:0] inner_tag_wanted;
		logic       decode_integer;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              data_valid;
		logic              done_res;
		logic [2:0]        status;
		logic [31:0]       value_length;
		logic signed [31:0] int_value;
	} res_t;

endpackage : dcfx_pkg
`default_nettype wire

[sv/dcfx_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcfx_parser
// TLV walker state. Each step consumes one content byte, updates the parse
// state and produces the result of that byte combinationally.
// ----------------------------------------------------------------------------
module dcfx_parser import dcfx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_val,
	input  wire logic       last,
	input  wire cfg_t       cfg,
	output res_t            res
);

	typedef enum logic [10:0] {
		PH_OTAG  = 11'b000_0000_0001,
		PH_OLEN  = 11'b000_0000_0010,
		PH_OLENX = 11'b000_0000_0100,
		PH_OSKIP = 11'b000_0000_1000,
		PH_ITAG  = 11'b000_0001_0000,
		PH_ILEN  = 11'b000_0010_0000,
		PH_ILENX = 11'b000_0100_0000,
		PH_VALUE = 11'b000_1000_0000,
		PH_WREST = 11'b001_0000_0000,
		PH_AFTER = 11'b010_0000_0000,
		PH_ERROR = 11'b100_0000_0000
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [31:0]          len_acc_q, len_acc_d;
	logic [LEN_CNT_W-1:0] len_left_q, len_left_d;
	logic [31:0]          elem_q, elem_d;
	logic [31:0]          wrap_q, wrap_d;
	logic                 cons_q, cons_d;
	logic [31:0]          cnt_q, cnt_d;
	logic [31:0]          int_acc_q, int_acc_d;
	logic [2:0]           rstat_q, rstat_d;
	logic                 hit_q, hit_d;

	logic [31:0] len_more_val;
	logic [31:0] wrap_dec;
	logic [31:0] elem_dec;
	logic [31:0] inner_rest;
	logic [6:0]  n_oct;
	logic        bad_form;
	logic        fin_outer;
	logic        fin_inner;
	logic [31:0] fin_len;
	logic        tag_supported;
	logic        int_len_bad;
	logic [2:0]  st;

	function automatic phase_t after_value(input logic [31:0] wrap);
		return (wrap != 32'd0) ? PH_WREST : PH_AFTER;
	endfunction

	assign len_more_val  = {len_acc_q[23:0], byte_val};
	assign wrap_dec      = wrap_q - 32'd1;
	assign elem_dec      = elem_q - 32'd1;
	assign n_oct         = byte_val[6:0] & LEN_COUNT_MASK;
	assign bad_form      = (n_oct == 7'd0) || (n_oct > 7'(MAX_LENGTH_OCTETS));
	// wrap_q - 1 - len, the room left once the inner length byte is taken.
	assign inner_rest    = wrap_q + ~fin_len;
	assign tag_supported = (cfg.inner_tag_wanted == TAG_OCTET_STRING)
	                    || (cfg.inner_tag_wanted == TAG_GENERAL_STRING)
	                    || (cfg.inner_tag_wanted == TAG_BMP_STRING)
	                    || (cfg.inner_tag_wanted == TAG_INTEGER);

	always_comb begin
		phase_d    = phase_q;
		len_acc_d  = len_acc_q;
		len_left_d = len_left_q;
		elem_d     = elem_q;
		wrap_d     = wrap_q;
		cons_d     = cons_q;
		cnt_d      = cnt_q;
		int_acc_d  = int_acc_q;
		rstat_d    = rstat_q;
		hit_d      = hit_q;
		fin_outer  = 1'b0;
		fin_inner  = 1'b0;
		fin_len    = '0;
		res        = '0;

		unique case (phase_q)
			PH_OTAG: begin
				hit_d = 1'b0;
				if (byte_val == (TAG_CTX_CONSTRUCTED | {3'b000, cfg.context_number})) begin
					hit_d  = 1'b1;
					cons_d = 1'b1;
				end else if (byte_val == (TAG_CTX_PRIMITIVE | {3'b000, cfg.context_number})) begin
					hit_d  = 1'b1;
					cons_d = 1'b0;
				end
				phase_d = PH_OLEN;
			end
			PH_OLEN: begin
				if (!byte_val[7]) begin
					len_acc_d = {24'd0, byte_val};
					fin_outer = 1'b1;
					fin_len   = {24'd0, byte_val};
				end else if (bad_form) begin
					phase_d = PH_ERROR;
				end else begin
					len_acc_d  = '0;
					len_left_d = n_oct[LEN_CNT_W-1:0];
					phase_d    = PH_OLENX;
				end
			end
			PH_OLENX: begin
				if (len_acc_q[31:24] != 8'd0) begin
					phase_d = PH_ERROR;
				end else begin
					len_acc_d  = len_more_val;
					len_left_d = len_left_q - LEN_CNT_W'(1);
					if (len_left_q == LEN_CNT_W'(1)) begin
						fin_outer = 1'b1;
						fin_len   = len_more_val;
					end
				end
			end
			PH_OSKIP: begin
				elem_d = elem_dec;
				if (elem_dec == 32'd0) begin
					phase_d = PH_OTAG;
				end
			end
			PH_ITAG: begin
				rstat_d = (byte_val == cfg.inner_tag_wanted) ? ST_FOUND : ST_TAG_MISS;
				wrap_d  = wrap_dec;
				phase_d = (wrap_dec == 32'd0) ? PH_ERROR : PH_ILEN;
			end
			PH_ILEN: begin
				wrap_d = wrap_dec;
				if (!byte_val[7]) begin
					len_acc_d = {24'd0, byte_val};
					fin_inner = 1'b1;
					fin_len   = {24'd0, byte_val};
				end else if (bad_form || ({25'd0, n_oct} > wrap_dec)) begin
					phase_d = PH_ERROR;
				end else begin
					len_acc_d  = '0;
					len_left_d = n_oct[LEN_CNT_W-1:0];
					phase_d    = PH_ILENX;
				end
			end
			PH_ILENX: begin
				wrap_d = wrap_dec;
				if (len_acc_q[31:24] != 8'd0) begin
					phase_d = PH_ERROR;
				end else begin
					len_acc_d  = len_more_val;
					len_left_d = len_left_q - LEN_CNT_W'(1);
					if (len_left_q == LEN_CNT_W'(1)) begin
						fin_inner = 1'b1;
						fin_len   = len_more_val;
					end
				end
			end
			PH_VALUE: begin
				if (rstat_q == ST_FOUND) begin
					res.data_byte  = byte_val;
					res.data_valid = 1'b1;
					cnt_d          = cnt_q + 32'd1;
					int_acc_d      = {int_acc_q[23:0], byte_val};
				end
				elem_d = elem_dec;
				if (elem_dec == 32'd0) begin
					phase_d = after_value(wrap_q);
				end
			end
			PH_WREST: begin
				wrap_d = wrap_dec;
				if (wrap_dec == 32'd0) begin
					phase_d = PH_AFTER;
				end
			end
			PH_AFTER, PH_ERROR: begin
			end
			default: begin
			end
		endcase

		if (fin_outer) begin
			if (!hit_q) begin
				elem_d  = fin_len;
				phase_d = (fin_len == 32'd0) ? PH_OTAG : PH_OSKIP;
			end else if (cons_q) begin
				wrap_d  = fin_len;
				phase_d = (fin_len == 32'd0) ? PH_ERROR : PH_ITAG;
			end else if (tag_supported) begin
				rstat_d = ST_FOUND;
				wrap_d  = '0;
				elem_d  = fin_len;
				phase_d = (fin_len == 32'd0) ? PH_AFTER : PH_VALUE;
			end else begin
				rstat_d = ST_TAG_MISS;
				wrap_d  = fin_len;
				phase_d = after_value(fin_len);
			end
		end

		// The inner length has to fit into what is left of the wrapper.
		if (fin_inner) begin
			if (fin_len >= wrap_q) begin
				phase_d = PH_ERROR;
			end else begin
				wrap_d  = inner_rest;
				elem_d  = fin_len;
				phase_d = (fin_len == 32'd0) ? after_value(inner_rest) : PH_VALUE;
			end
		end

		int_len_bad = (cnt_d == 32'd0) || (cnt_d[31:3] != 29'd0)
		           || (cnt_d[2] && (cnt_d[1:0] != 2'd0));
		if (phase_d == PH_OTAG) begin
			st = ST_NOT_FOUND;
		end else if (phase_d == PH_AFTER) begin
			st = (rstat_d == ST_FOUND && cfg.decode_integer && int_len_bad) ? ST_BAD_INT
			                                                                : rstat_d;
		end else begin
			st = ST_MALFORMED;
		end

		if (last) begin
			res.done_res = 1'b1;
			res.status   = st;
			if (st == ST_FOUND || st == ST_BAD_INT) begin
				res.value_length = cnt_d;
			end
			if (st == ST_FOUND && cfg.decode_integer) begin
				unique case (cnt_d[2:0])
					3'd1:    res.int_value = {{24{int_acc_d[7]}}, int_acc_d[7:0]};
					3'd2:    res.int_value = {{16{int_acc_d[15]}}, int_acc_d[15:0]};
					3'd3:    res.int_value = {{8{int_acc_d[23]}}, int_acc_d[23:0]};
					default: res.int_value = int_acc_d;
				endcase
			end
			// A new sequence starts with the next byte.
			phase_d    = PH_OTAG;
			len_acc_d  = '0;
			len_left_d = '0;
			elem_d     = '0;
			wrap_d     = '0;
			cons_d     = 1'b0;
			cnt_d      = '0;
			int_acc_d  = '0;
			rstat_d    = ST_NOT_FOUND;
			hit_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OTAG;
			len_acc_q  <= '0;
			len_left_q <= '0;
			elem_q     <= '0;
			wrap_q     <= '0;
			cons_q     <= 1'b0;
			cnt_q      <= '0;
			int_acc_q  <= '0;
			rstat_q    <= ST_NOT_FOUND;
			hit_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			len_acc_q  <= len_acc_d;
			len_left_q <= len_left_d;
			elem_q     <= elem_d;
			wrap_q     <= wrap_d;
			cons_q     <= cons_d;
			cnt_q      <= cnt_d;
			int_acc_q  <= int_acc_d;
			rstat_q    <= rstat_d;
			hit_q      <= hit_d;
		end
	end

endmodule : dcfx_parser
`default_nettype wire

[sv/der_context_field_extractor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// der_context_field_extractor
// Walks the content of a DER SEQUENCE one byte per request, passes out the
// bytes of the first [n] element's value and reports status on the last byte.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_ready    byte_in, last_byte
//  res       res_valid/res_ready  data_byte, data_valid, done_res, status,
//                                 value_length, int_value
//  cfg       APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One request is taken per cycle unless res_ready stalls; each result passes from the
// input register through the parse step into the result register.
// A stall on res_ready backs up through the input register to in_ready.
// Reset is asynchronous and returns the parse state, configuration and valid flags at once.
// ----------------------------------------------------------------------------
module der_context_field_extractor import dcfx_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         byte_in,
	input  wire logic               last_byte,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [7:0]              data_byte,
	output logic                    data_valid,
	output logic                    done_res,
	output logic [2:0]              status,
	output logic [31:0]             value_length,
	output logic signed [31:0]      int_value
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res_d;
	logic       advance;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.context_number   <= 5'd0;
			cfg_q.inner_tag_wanted <= TAG_INTEGER;
			cfg_q.decode_integer   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CONTEXT_NUMBER:   cfg_q.context_number   <= pwdata[4:0];
				REG_INNER_TAG_WANTED: cfg_q.inner_tag_wanted <= pwdata[7:0];
				REG_DECODE_INTEGER:   cfg_q.decode_integer   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CONTEXT_NUMBER:   prdata = {27'd0, cfg_q.context_number};
			REG_INNER_TAG_WANTED: prdata = {24'd0, cfg_q.inner_tag_wanted};
			REG_DECODE_INTEGER:   prdata = {31'd0, cfg_q.decode_integer};
			default:              prdata = '0;
		endcase
	end

	assign advance  = valid_s1 && (!valid_s2 || res_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			last_s1 <= last_byte;
		end
	end

	dcfx_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.byte_val (byte_s1),
		.last     (last_s1),
		.cfg      (cfg_q),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid    = valid_s2;
	assign data_byte    = res_s2.data_byte;
	assign data_valid   = res_s2.data_valid;
	assign done_res     = res_s2.done_res;
	assign status       = res_s2.status;
	assign value_length = res_s2.value_length;
	assign int_value    = res_s2.int_value;

endmodule : der_context_field_extractor
`default_nettype wire

[sv/dcfx_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcfx_checker
// Port-level checks on the result channel of the extractor, bound to the top.
// ----------------------------------------------------------------------------
module dcfx_checker import dcfx_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [7:0]        data_byte,
	input wire logic              data_valid,
	input wire logic              done_res,
	input wire logic [2:0]        status,
	input wire logic [31:0]       value_length,
	input wire logic signed [31:0] int_value
);

	// A result that is held back must not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(data_valid)
			&& $stable(done_res) && $stable(status) && $stable(value_length)
			&& $stable(int_value))
		else $error("result changed while stalled");

	// Status fields only carry information on the final byte of a sequence.
	a_quiet_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> status == ST_FOUND && value_length == 32'd0
			&& int_value == 32'sd0)
		else $error("status fields set before the last byte");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_valid |-> data_byte == 8'd0)
		else $error("data byte set without data_valid");

	// Only a found value or a bad integer length reports a length, and only
	// a found value reports an integer.
	a_len_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res && status != ST_FOUND && status != ST_BAD_INT
			|-> value_length == 32'd0 && int_value == 32'sd0)
		else $error("length reported with a failing status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> status == ST_FOUND || status == ST_NOT_FOUND
			|| status == ST_MALFORMED || status == ST_TAG_MISS || status == ST_BAD_INT)
		else $error("unknown status code");

endmodule : dcfx_checker

bind der_context_field_extractor dcfx_checker u_dcfx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.data_byte    (data_byte),
	.data_valid   (data_valid),
	.done_res     (done_res),
	.status       (status),
	.value_length (value_length),
	.int_value    (int_value)
);
`default_nettype wire
